FILE: hw/rtl/fjp_pkg.sv
package fjp_pkg;

	localparam int unsigned PAIR_LIMIT_DEF   = 32;
	localparam int unsigned KEY_BUFFER_DEF   = 256;
	localparam int unsigned VALUE_BUFFER_DEF = 256;

	localparam logic [1:0] KIND_NONE  = 2'd0;
	localparam logic [1:0] KIND_KEY   = 2'd1;
	localparam logic [1:0] KIND_VALUE = 2'd2;
	localparam logic [1:0] KIND_PAIR  = 2'd3;

	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_QUOTE  = 8'h22;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       line_end;
	} in_word_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] out_byte;
		logic [4:0] pair_index;
		logic       line_done;
		logic       line_ok;
	} out_word_t;

endpackage

FILE: hw/rtl/flat_json_pair_parser.sv
// channel | signals                               | payload
// input   | in_valid, in_ready, in_data           | in_word_t: in_byte, line_end
// output  | out_valid, out_ready, out_data        | out_word_t: kind .. line_ok
//
// One word in, one word out; a new word is taken every cycle while in_ready is high.
// Each result is ready in the cycle after its word is taken (result register).
// in_ready is high while the result register is empty or being drained.
// Reset returns the parser to waiting for the opening brace, output empty.
module flat_json_pair_parser #(
	parameter int unsigned PAIR_LIMIT   = fjp_pkg::PAIR_LIMIT_DEF,
	parameter int unsigned KEY_BUFFER   = fjp_pkg::KEY_BUFFER_DEF,
	parameter int unsigned VALUE_BUFFER = fjp_pkg::VALUE_BUFFER_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  fjp_pkg::in_word_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output fjp_pkg::out_word_t out_data
);
	import fjp_pkg::*;

	out_word_t res;
	out_word_t res_q;
	logic      valid_q;
	logic      take;

	assign in_ready  = !valid_q || out_ready;
	assign take      = in_valid && in_ready;
	assign out_valid = valid_q;
	assign out_data  = res_q;

	fjp_core #(
		.PAIR_LIMIT  (PAIR_LIMIT),
		.KEY_BUFFER  (KEY_BUFFER),
		.VALUE_BUFFER(VALUE_BUFFER)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.word_in (in_data),
		.word_out(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q <= res;
		end
	end

endmodule

FILE: hw/rtl/fjp_core.sv
module fjp_core #(
	parameter int unsigned PAIR_LIMIT   = fjp_pkg::PAIR_LIMIT_DEF,
	parameter int unsigned KEY_BUFFER   = fjp_pkg::KEY_BUFFER_DEF,
	parameter int unsigned VALUE_BUFFER = fjp_pkg::VALUE_BUFFER_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  fjp_pkg::in_word_t word_in,
	output fjp_pkg::out_word_t word_out
);
	import fjp_pkg::*;

	typedef enum logic [2:0] {
		PH_PRE, PH_TOP, PH_SEP, PH_KEY, PH_COLON, PH_VQUOTE, PH_VALUE, PH_DONE
	} phase_t;

	localparam logic [7:0] KEY_MAX   = 8'(KEY_BUFFER - 1);
	localparam logic [7:0] VALUE_MAX = 8'(VALUE_BUFFER - 1);
	localparam logic [5:0] LIMIT     = 6'(PAIR_LIMIT);

	phase_t     phase_q, phase_n;
	logic [7:0] len_q, len_n;
	logic [5:0] pairs_q, pairs_n, pairs_inc;
	logic       verdict_q, verdict_n;
	logic [7:0] c;
	logic       sp_tab, blank;

	assign c         = word_in.in_byte;
	assign sp_tab    = (c == CH_SPACE) || (c == CH_TAB);
	assign blank     = sp_tab || (c == CH_NL);
	assign pairs_inc = pairs_q + 6'd1;

	always_comb begin
		phase_n   = phase_q;
		len_n     = len_q;
		pairs_n   = pairs_q;
		verdict_n = verdict_q;
		word_out  = '0;
		unique case (phase_q)
			PH_PRE: begin
				if (c == CH_LBRACE) begin
					phase_n = PH_TOP;
				end else if (!blank) begin
					phase_n   = PH_DONE;
					verdict_n = 1'b0;
				end
			end
			PH_TOP, PH_SEP: begin
				if (c == CH_RBRACE) begin
					phase_n   = PH_DONE;
					verdict_n = 1'b1;
				end else if (c == CH_QUOTE) begin
					phase_n = PH_KEY;
					len_n   = '0;
				end else if (blank || c == CH_COMMA) begin
					phase_n = PH_SEP;
				end else begin
					phase_n   = PH_DONE;
					verdict_n = 1'b0;
				end
			end
			PH_KEY: begin
				if (c == CH_QUOTE) begin
					phase_n = PH_COLON;
				end else if (len_q < KEY_MAX) begin
					word_out.kind       = KIND_KEY;
					word_out.out_byte   = c;
					word_out.pair_index = pairs_q[4:0];
					len_n               = len_q + 8'd1;
				end else begin
					phase_n   = PH_DONE;
					verdict_n = 1'b0;
				end
			end
			PH_COLON: begin
				if (c == CH_COLON) begin
					phase_n = PH_VQUOTE;
				end else if (!sp_tab) begin
					phase_n   = PH_DONE;
					verdict_n = 1'b0;
				end
			end
			PH_VQUOTE: begin
				if (c == CH_QUOTE) begin
					phase_n = PH_VALUE;
					len_n   = '0;
				end else if (!sp_tab) begin
					phase_n   = PH_DONE;
					verdict_n = 1'b0;
				end
			end
			PH_VALUE: begin
				if (c == CH_QUOTE) begin
					word_out.kind       = KIND_PAIR;
					word_out.pair_index = pairs_q[4:0];
					pairs_n             = pairs_inc;
					if (pairs_inc >= LIMIT) begin
						phase_n   = PH_DONE;
						verdict_n = 1'b1;
					end else begin
						phase_n = PH_TOP;
					end
				end else if (len_q < VALUE_MAX) begin
					word_out.kind       = KIND_VALUE;
					word_out.out_byte   = c;
					word_out.pair_index = pairs_q[4:0];
					len_n               = len_q + 8'd1;
				end else begin
					phase_n   = PH_DONE;
					verdict_n = 1'b0;
				end
			end
			PH_DONE: begin
			end
		endcase
		if (word_in.line_end) begin
			word_out.line_done = 1'b1;
			word_out.line_ok   = (phase_n == PH_TOP) || (phase_n == PH_DONE && verdict_n);
			phase_n   = PH_PRE;
			len_n     = '0;
			pairs_n   = '0;
			verdict_n = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_PRE;
			len_q     <= '0;
			pairs_q   <= '0;
			verdict_q <= 1'b0;
		end else if (take) begin
			phase_q   <= phase_n;
			len_q     <= len_n;
			pairs_q   <= pairs_n;
			verdict_q <= verdict_n;
		end
	end

endmodule
